// ----- rtl/rgb_conv3x3_filter_unit_defines.svh -----
// Assertion macros shared by the RTL files.
`ifndef RGB_CONV3X3_FILTER_UNIT_DEFINES_SVH
`define RGB_CONV3X3_FILTER_UNIT_DEFINES_SVH

// Check that a condition at one edge implies another at the same edge.
`define RCF_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Check that a condition at one edge implies another at the next edge.
`define RCF_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/rcf_pkg.sv -----
package rcf_pkg;

  localparam int unsigned MaxLineLengthDef = 512;
  localparam int unsigned MaxLineCountDef  = 512;
  localparam int unsigned CfgIdxW          = 3;
  localparam int unsigned CfgDataW         = 24;
  localparam int unsigned GeomW            = 10;

  localparam logic [CfgIdxW-1:0] RegCoefTop    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoefMid    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoefBottom = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGain       = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTapOffset  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLineLength = 3'd5;
  localparam logic [CfgIdxW-1:0] RegLineCount  = 3'd6;

  localparam logic FuncPixel = 1'b0;
  localparam logic FuncDrain = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } out_item_t;

  // Queue entry between the window front and the arithmetic back.
  typedef struct packed {
    logic [8:0][23:0] taps;
    logic             last;
  } job_t;

  function automatic logic [7:0] chan_of(input logic [23:0] pix, input int unsigned ch);
    logic [7:0] b;
    b = pix[8*ch +: 8];
    return b;
  endfunction

endpackage

// ----- rtl/rcf_front.sv -----
module rcf_front
  import rcf_pkg::*;
#(
  parameter int unsigned MAX_LINE_LENGTH = MaxLineLengthDef,
  parameter int unsigned MAX_LINE_COUNT  = MaxLineCountDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  input  logic [GeomW-1:0] line_length,
  input  logic [GeomW-1:0] line_count,
  input  logic             restart,
  output logic             job_valid,
  input  logic             job_ready,
  output job_t             job
);

  localparam int unsigned AddrW = $clog2(MAX_LINE_LENGTH);
  localparam int unsigned PosW  = $clog2(MAX_LINE_COUNT + 2);
  localparam int unsigned CntW  = $clog2(MAX_LINE_LENGTH * MAX_LINE_COUNT + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_t;

  state_t               state_r;
  logic [23:0]          store_a [MAX_LINE_LENGTH];
  logic [23:0]          store_b [MAX_LINE_LENGTH];
  logic [23:0]          rd_a_r, rd_b_r;
  logic [8:0][23:0]     win_r;
  logic [GeomW-1:0]     inner_r;
  logic [PosW-1:0]      outer_r;
  logic [CntW-1:0]      count_r;
  logic [23:0]          pix_r;
  job_t                 pend_r;
  job_t                 job_r;
  logic                 job_valid_r;

  logic                 is_drain;
  logic [AddrW-1:0]     addr;
  logic [8:0][23:0]     win_nxt;
  logic                 emit_prev, emit_cur, emit;
  logic                 last_job;
  logic [8:0][23:0]     taps;
  logic [CntW-1:0]      total;
  logic                 in_frame;
  logic [PosW:0]        row0;

  assign in_frame  = PosW'(line_count) > outer_r;
  assign is_drain  = in_data.func == FuncDrain;
  assign in_ready  = state_r == ST_IDLE && !restart;
  assign job_valid = job_valid_r;
  assign job       = job_r;
  assign total     = CntW'(line_length) * CntW'(line_count);
  assign last_job  = emit && count_r == total - CntW'(1);

  always_comb begin
    if ({{(32-GeomW){1'b0}}, inner_r} >= MAX_LINE_LENGTH) begin
      addr = AddrW'(MAX_LINE_LENGTH - 1);
    end else begin
      addr = AddrW'(inner_r);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      store_a[addr] <= rd_b_r;
      store_b[addr] <= pix_r;
    end
    rd_a_r <= store_a[addr];
    rd_b_r <= store_b[addr];
  end

  always_comb begin
    win_nxt = win_r;
    for (int r = 0; r < 3; r++) begin
      win_nxt[r*3+0] = win_r[r*3+1];
      win_nxt[r*3+1] = win_r[r*3+2];
    end
    win_nxt[2] = rd_a_r;
    win_nxt[5] = rd_b_r;
    win_nxt[8] = pix_r;
  end

  always_comb begin
    emit_prev = inner_r == '0 && outer_r >= PosW'(2);
    emit_cur  = inner_r != '0 && outer_r >= PosW'(1);
    emit      = (emit_prev || emit_cur) && count_r < total;
    taps      = '0;
    row0      = '0;
    for (int r = 0; r < 3; r++) begin
      if (emit_cur) begin
        row0 = {1'b0, outer_r} + (PosW+1)'(r);
        if (row0 >= (PosW+1)'(2) && row0 - (PosW+1)'(2) < (PosW+1)'(line_count)) begin
          for (int k = 0; k < 3; k++) begin
            if ({1'b0, inner_r} + (GeomW+1)'(k) >= (GeomW+1)'(2)) begin
              taps[r*3+k] = win_nxt[r*3+k];
            end
          end
        end
      end else begin
        row0 = {1'b0, outer_r} + (PosW+1)'(r);
        if (row0 >= (PosW+1)'(3) && row0 - (PosW+1)'(3) < (PosW+1)'(line_count)) begin
          taps[r*3+0] = win_r[r*3+1];
          taps[r*3+1] = win_r[r*3+2];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= '0;
      inner_r     <= '0;
      outer_r     <= '0;
      count_r     <= '0;
      job_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_SEND && (!job_valid_r || job_ready)) begin
        job_valid_r <= 1'b1;
      end else if (job_ready) begin
        job_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (restart) begin
            inner_r <= '0;
            outer_r <= '0;
            count_r <= '0;
          end else if (in_valid) begin
            if (in_frame && is_drain) begin
              state_r <= ST_IDLE;
            end else begin
              pix_r   <= in_frame ? {in_data.blue_in, in_data.green_in, in_data.red_in}
                                  : 24'd0;
              state_r <= ST_READ;
            end
          end
        end
        ST_READ: begin
          win_r <= win_nxt;
          if (last_job) begin
            inner_r <= '0;
            outer_r <= '0;
            count_r <= '0;
          end else begin
            if (inner_r + GeomW'(1) >= line_length) begin
              inner_r <= '0;
              outer_r <= outer_r + PosW'(1);
            end else begin
              inner_r <= inner_r + GeomW'(1);
            end
            if (emit) begin
              count_r <= count_r + CntW'(1);
            end
          end
          if (emit) begin
            pend_r.taps <= taps;
            pend_r.last <= last_job;
            state_r     <= ST_SEND;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_SEND: begin
          if (!job_valid_r || job_ready) begin
            job_r   <= pend_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `include "rgb_conv3x3_filter_unit_defines.svh"
  `RCF_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_r == ST_IDLE, "ready outside idle")
  `RCF_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r < total || count_r == '0, "count overrun")
  `RCF_ASSERT_NEXT(a_send_hold, clk, rst_n, state_r == ST_SEND && job_valid_r && !job_ready, state_r == ST_SEND, "send lost")

endmodule

// ----- rtl/rcf_back.sv -----
module rcf_back
  import rcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  input  logic [23:0] coef_top,
  input  logic [23:0] coef_mid,
  input  logic [23:0] coef_bot,
  input  logic [23:0] gain,
  input  logic [15:0] tap_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_SCALE,
    ST_DONE
  } state_t;

  state_t                  state_r;
  job_t                    job_r;
  logic [1:0]              ch_r;
  logic signed [19:0]      sum_r;
  logic signed [47:0]      prod_r;
  logic [2:0][7:0]         res_r;
  logic                    out_valid_r;
  out_item_t               out_r;

  logic signed [19:0]      sum;
  logic signed [8:0]       coef;
  logic [23:0]             crow;
  logic signed [49:0]      v;

  assign job_ready = state_r == ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sum  = '0;
    crow = '0;
    coef = '0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        crow = k == 0 ? coef_top : (k == 1 ? coef_mid : coef_bot);
        coef = {crow[8*r+7], crow[8*r +: 8]};
        sum  = sum + 20'(coef) *
               20'($signed({1'b0, chan_of(job_r.taps[r*3+k], 32'(ch_r))}));
      end
    end
    v = 50'(prod_r) + 50'($signed(tap_offset)) * 50'sd2304;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ch_r        <= '0;
    end else begin
      if (state_r == ST_DONE && ch_r == 2'd2 && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            job_r   <= job;
            ch_r    <= '0;
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          sum_r   <= sum;
          state_r <= ST_SCALE;
        end
        ST_SCALE: begin
          prod_r  <= 48'(sum_r) * $signed({24'd0, gain});
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (v < 0) begin
            res_r[ch_r] <= 8'd0;
          end else if (v > 50'sd16711680) begin
            res_r[ch_r] <= 8'd255;
          end else begin
            res_r[ch_r] <= v[23:16];
          end
          if (ch_r == 2'd2) begin
            if (!out_valid_r || out_ready) begin
              out_r.red_out    <= res_r[0];
              out_r.green_out  <= res_r[1];
              out_r.blue_out   <= v < 0 ? 8'd0 : (v > 50'sd16711680 ? 8'd255 : v[23:16]);
              out_r.frame_last <= job_r.last;
              state_r          <= ST_IDLE;
            end
          end else begin
            ch_r    <= ch_r + 2'd1;
            state_r <= ST_SUM;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `include "rgb_conv3x3_filter_unit_defines.svh"
  `RCF_ASSERT_IMP(a_ch_range, clk, rst_n, 1'b1, ch_r != 2'd3, "bad channel")
  `RCF_ASSERT_NEXT(a_take_job, clk, rst_n, job_valid && job_ready, state_r == ST_SUM, "job dropped")
  `RCF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_ready, out_valid_r, "result lost")

endmodule

// ----- rtl/rgb_conv3x3_filter_unit.sv -----
// 3x3 RGB convolution filter over a raster pixel stream with two line stores
// and a zero-padded window. An item that moves the window passes the front's
// accept state with the line store read, its window update state and, if it
// yields a job, a send state to the back; an ignored drain is only accepted.
// The back takes a job when idle and runs three steps per color channel (sum,
// gain multiply, round and clamp) on its shared multiply-accumulate path,
// taking no new job until its result is out. Results for a pixel come out one
// line plus one pixel after it enters; line_length + 1 drain items flush the
// tail. Writing line_length or line_count restarts the frame.
module rgb_conv3x3_filter_unit
  import rcf_pkg::*;
#(
  parameter int unsigned MAX_LINE_LENGTH = MaxLineLengthDef,
  parameter int unsigned MAX_LINE_COUNT  = MaxLineCountDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [23:0]      coef_top_r, coef_mid_r, coef_bot_r, gain_r;
  logic [15:0]      tap_offset_r;
  logic [GeomW-1:0] line_length_r, line_count_r;
  logic             restart;
  logic             job_valid, job_ready;
  job_t             job;

  function automatic logic [GeomW-1:0] clamp_geom(input logic [GeomW-1:0] v,
                                                  input int unsigned hi);
    logic [GeomW-1:0] r;
    if (v < GeomW'(3)) begin
      r = GeomW'(3);
    end else if ({{(32-GeomW){1'b0}}, v} > hi) begin
      r = GeomW'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign restart = cfg_we && (cfg_index == RegLineLength || cfg_index == RegLineCount);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_top_r    <= 24'hFFFFFF;
      coef_mid_r    <= 24'hFF09FF;
      coef_bot_r    <= 24'hFFFFFF;
      gain_r        <= 24'd65536;
      tap_offset_r  <= 16'd128;
      line_length_r <= clamp_geom(GeomW'(512), MAX_LINE_LENGTH);
      line_count_r  <= clamp_geom(GeomW'(512), MAX_LINE_COUNT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegCoefTop:    coef_top_r    <= cfg_data;
        RegCoefMid:    coef_mid_r    <= cfg_data;
        RegCoefBottom: coef_bot_r    <= cfg_data;
        RegGain:       gain_r        <= cfg_data;
        RegTapOffset:  tap_offset_r  <= cfg_data[15:0];
        RegLineLength: line_length_r <= clamp_geom(cfg_data[GeomW-1:0], MAX_LINE_LENGTH);
        RegLineCount:  line_count_r  <= clamp_geom(cfg_data[GeomW-1:0], MAX_LINE_COUNT);
        default: ;
      endcase
    end
  end

  rcf_front #(
    .MAX_LINE_LENGTH(MAX_LINE_LENGTH),
    .MAX_LINE_COUNT (MAX_LINE_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .line_length(line_length_r),
    .line_count (line_count_r),
    .restart    (restart),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job        (job)
  );

  rcf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .coef_top  (coef_top_r),
    .coef_mid  (coef_mid_r),
    .coef_bot  (coef_bot_r),
    .gain      (gain_r),
    .tap_offset(tap_offset_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- tb/rgb_conv3x3_filter_unit_tb.sv -----
`timescale 1ns / 1ps

module rgb_conv3x3_filter_unit_tb;
  import rcf_pkg::*;

  localparam int unsigned LineMax    = 512;
  localparam int unsigned SettleCyc  = 64;
  localparam int unsigned CycleLimit = 2000000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  rgb_conv3x3_filter_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  in_item_t    pixels_pending[$];
  out_item_t   expected_pixels[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          in_taken;
  bit          out_taken;
  int unsigned in_gap;
  int unsigned out_stall;
  bit          no_idle;

  // Filter state mirror
  logic [23:0] coef_rows[3];
  logic [23:0] gain;
  int          tap_off;
  int unsigned line_len;
  int unsigned line_cnt;
  logic [23:0] store_a[LineMax];
  logic [23:0] store_b[LineMax];
  logic [23:0] window[9];
  logic [23:0] taps[3][3];
  int unsigned inner_pos;
  int unsigned outer_pos;
  int unsigned emitted;

  function automatic int unsigned clamp_geom(logic [9:0] v);
    if (v < 3) return 3;
    if (v > LineMax) return LineMax;
    return v;
  endfunction

  function automatic void restart_frame();
    inner_pos = 0;
    outer_pos = 0;
    emitted   = 0;
  endfunction

  function automatic void filter_reset();
    coef_rows[0] = 24'hFFFFFF;
    coef_rows[1] = 24'hFF09FF;
    coef_rows[2] = 24'hFFFFFF;
    gain         = 24'd65536;
    tap_off      = 128;
    line_len     = LineMax;
    line_cnt     = LineMax;
    for (int i = 0; i < LineMax; i++) begin
      store_a[i] = '0;
      store_b[i] = '0;
    end
    for (int i = 0; i < 9; i++) window[i] = '0;
    restart_frame();
  endfunction

  function automatic void filter_config(logic [CfgIdxW-1:0] idx, logic [23:0] val);
    case (idx)
      RegCoefTop, RegCoefMid, RegCoefBottom: coef_rows[idx[1:0]] = val;
      RegGain: gain = val;
      RegTapOffset: tap_off = int'($signed(val[15:0]));
      RegLineLength: begin
        line_len = clamp_geom(val[9:0]);
        restart_frame();
      end
      RegLineCount: begin
        line_cnt = clamp_geom(val[9:0]);
        restart_frame();
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] filter_channel(int ch);
    int     acc;
    longint v;
    acc = 0;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        acc += int'($signed(coef_rows[k][8*r +: 8])) * int'(taps[r][k][8*ch +: 8]);
    v = longint'(acc) * longint'(gain) + longint'(9 * tap_off * 256);
    if (v < 0) return 8'd0;
    if (v > 255 * 65536) return 8'd255;
    return v[23:16];
  endfunction

  function automatic bit filter_step(in_item_t it, output out_item_t res);
    logic [23:0] pix;
    logic [23:0] col[3];
    int          x, c, n, row;
    bit          emit, ok;
    int unsigned total;
    x = outer_pos;
    c = inner_pos;
    n = line_cnt;
    emit = 0;
    res = '0;
    if (x < n) begin
      if (it.func == FuncDrain) return 0;
      pix = {it.blue_in, it.green_in, it.red_in};
    end else begin
      pix = '0;
    end
    if (c == 0 && x >= 2) begin
      emit = 1;
      for (int r = 0; r < 3; r++) begin
        row = x - 3 + r;
        ok = row >= 0 && row < n;
        taps[r][0] = ok ? window[r*3+1] : '0;
        taps[r][1] = ok ? window[r*3+2] : '0;
        taps[r][2] = '0;
      end
    end
    col[0] = store_a[inner_pos];
    col[1] = store_b[inner_pos];
    col[2] = pix;
    store_a[inner_pos] = col[1];
    store_b[inner_pos] = pix;
    for (int r = 0; r < 3; r++) begin
      window[r*3+0] = window[r*3+1];
      window[r*3+1] = window[r*3+2];
      window[r*3+2] = col[r];
    end
    if (c >= 1 && x >= 1) begin
      emit = 1;
      for (int r = 0; r < 3; r++) begin
        row = x - 2 + r;
        for (int k = 0; k < 3; k++) begin
          ok = row >= 0 && row < n && (c - 2 + k >= 0);
          taps[r][k] = ok ? window[r*3+k] : '0;
        end
      end
    end
    if (inner_pos + 1 >= line_len) begin
      inner_pos = 0;
      outer_pos++;
    end else begin
      inner_pos++;
    end
    total = line_len * line_cnt;
    if (!emit || emitted >= total) return 0;
    res.red_out    = filter_channel(0);
    res.green_out  = filter_channel(1);
    res.blue_out   = filter_channel(2);
    res.frame_last = (emitted == total - 1);
    emitted++;
    if (res.frame_last) restart_frame();
    return 1;
  endfunction

  function automatic logic [7:0] pick_chan();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_item_t make_item(logic f);
    in_item_t it;
    it.func     = f;
    it.red_in   = pick_chan();
    it.green_in = pick_chan();
    it.blue_in  = pick_chan();
    return it;
  endfunction

  function automatic void enqueue_item(in_item_t it);
    pixels_pending = {pixels_pending, it};
  endfunction

  // Queue one full frame plus its flush tail; noise adds ignored drains mid-frame.
  task automatic queue_frame(bit noise, inout int unsigned sent);
    for (int unsigned i = 0; i < line_len * line_cnt; i++) begin
      if (noise && $urandom_range(0, 15) == 0) enqueue_item(make_item(FuncDrain));
      enqueue_item(make_item(FuncPixel));
      sent++;
    end
    for (int unsigned i = 0; i <= line_len; i++)
      enqueue_item(make_item($urandom_range(0, 3) == 0 ? FuncPixel : FuncDrain));
  endtask

  task automatic wait_idle();
    while (pixels_pending.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    filter_config(idx, val);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    in_item_t  it;
    out_item_t res;
    out_item_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    in_taken  <= in_valid && in_ready;
    out_taken <= out_valid && out_ready;
    if (rst_n && in_valid && in_ready) begin
      it = in_data;
      if (filter_step(it, res)) expected_pixels = {expected_pixels, res};
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", out_data);
      end else begin
        want = expected_pixels.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %p, got %p", want, out_data);
        end
      end
    end
  end

  always @(negedge clk) begin
    int unsigned stall_draw;
    if (!(in_valid && !in_taken)) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pixels_pending.size() != 0) begin
        in_data  <= pixels_pending.pop_front();
        in_valid <= 1'b1;
        in_gap   <= no_idle ? 0 : $urandom_range(0, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (out_taken) begin
      stall_draw = no_idle ? 0 : $urandom_range(0, 15);
      out_stall <= stall_draw;
      out_ready <= stall_draw == 0;
    end else if (out_stall > 1) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_stall <= 0;
      out_ready <= 1'b1;
    end
  end

  initial begin
    int unsigned sent;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    mismatches = 0;
    cycles     = 0;
    in_gap     = 0;
    out_stall  = 0;
    no_idle    = 1'b0;
    sent       = 0;
    filter_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Smallest frame with the reset kernel: extremes, an ignored drain, pixel in the tail.
    write_reg(RegLineLength, 24'd3);
    write_reg(RegLineCount, 24'd3);
    end_writes();
    enqueue_item('{FuncPixel, 8'h00, 8'h00, 8'h00});
    enqueue_item('{FuncDrain, 8'hFF, 8'hFF, 8'hFF});
    enqueue_item('{FuncPixel, 8'hFF, 8'hFF, 8'hFF});
    enqueue_item('{FuncPixel, 8'hFF, 8'h00, 8'hFF});
    enqueue_item('{FuncPixel, 8'h00, 8'hFF, 8'h00});
    enqueue_item('{FuncPixel, 8'hFF, 8'hFF, 8'hFF});
    enqueue_item('{FuncPixel, 8'h80, 8'h7F, 8'h01});
    enqueue_item('{FuncPixel, 8'h00, 8'h00, 8'h00});
    enqueue_item('{FuncPixel, 8'hAA, 8'h55, 8'hFE});
    enqueue_item('{FuncPixel, 8'h01, 8'h80, 8'h00});
    enqueue_item('{FuncPixel, 8'h12, 8'h34, 8'h56});
    enqueue_item('{FuncDrain, 8'h00, 8'h00, 8'h00});
    enqueue_item('{FuncDrain, 8'h00, 8'h00, 8'h00});
    enqueue_item('{FuncDrain, 8'h00, 8'h00, 8'h00});
    wait_idle();

    // Extreme coefficients, gain and offset; index past the list is ignored.
    write_reg(RegCoefTop, 24'h808080);
    write_reg(RegCoefMid, 24'h7F7F7F);
    write_reg(RegCoefBottom, 24'h80FF7F);
    write_reg(RegGain, 24'hFFFFFF);
    write_reg(RegTapOffset, 24'h008000);
    write_reg(3'd7, 24'h123456);
    write_reg(RegLineLength, 24'd0);
    write_reg(RegLineCount, 24'd1);
    end_writes();
    queue_frame(1'b1, sent);
    wait_idle();
    write_reg(RegGain, 24'd0);
    write_reg(RegTapOffset, 24'h007FFF);
    end_writes();
    queue_frame(1'b0, sent);
    wait_idle();

    sent = 0;
    while (sent < 400) begin
      no_idle = ($urandom_range(0, 4) == 0);
      write_reg(RegCoefTop, 24'($urandom));
      write_reg(RegCoefMid, 24'($urandom));
      write_reg(RegCoefBottom, 24'($urandom));
      write_reg(RegGain, $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 24'h30000)));
      write_reg(RegTapOffset, 24'($urandom));
      write_reg(RegLineLength, 24'($urandom_range(0, 12)));
      write_reg(RegLineCount, 24'($urandom_range(0, 8)));
      end_writes();
      queue_frame(1'b1, sent);
      wait_idle();
    end

    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rcf_pkg.sv
rtl/rcf_front.sv
rtl/rcf_back.sv
rtl/rgb_conv3x3_filter_unit.sv
tb/rgb_conv3x3_filter_unit_tb.sv
